FILE: design/rfft_pkg.sv
// Shared types, constants, twiddle tables and helpers for the radix-2 frame FFT.
package rfft_pkg;

   localparam int ADDR_W      = 6;
   localparam int CNT_W       = 7;
   localparam int LOG2_W      = 3;
   localparam int TW_W        = 17;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int TW_DEPTH    = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_LOG2_POINTS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAD_ENABLE  = 1'b1;

   localparam logic [LOG2_W-1:0] LOG2_RESET = 3'd6;
   localparam logic              PAD_RESET  = 1'b1;

   // Command handed from the front end to the back end, one per accepted word.
   typedef struct packed {
      logic              store;
      logic              last;
      logic              reject;
      logic              pad;
      logic [LOG2_W-1:0] log2n;
      logic [ADDR_W-1:0] addr;
      logic [CNT_W-1:0]  pad_from;
   } cmd_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_PAD,
      B_FFT,
      B_DRAIN,
      B_EMIT,
      B_ERROR
   } back_state_type;

   // Q2.15 cosine and sine of 2*pi*k/64, with +1.0 held as 32767.
   localparam logic signed [TW_W-1:0] TW_COS [TW_DEPTH] = '{
      17'sd32767, 17'sd32610, 17'sd32138, 17'sd31357, 17'sd30274, 17'sd28899,
      17'sd27246, 17'sd25330, 17'sd23170, 17'sd20788, 17'sd18205, 17'sd15447,
      17'sd12540, 17'sd9512, 17'sd6393, 17'sd3212, 17'sd0, -17'sd3212,
      -17'sd6393, -17'sd9512, -17'sd12540, -17'sd15447, -17'sd18205, -17'sd20788,
      -17'sd23170, -17'sd25330, -17'sd27246, -17'sd28899, -17'sd30274, -17'sd31357,
      -17'sd32138, -17'sd32610
   };

   localparam logic signed [TW_W-1:0] TW_SIN [TW_DEPTH] = '{
      17'sd0, 17'sd3212, 17'sd6393, 17'sd9512, 17'sd12540, 17'sd15447,
      17'sd18205, 17'sd20788, 17'sd23170, 17'sd25330, 17'sd27246, 17'sd28899,
      17'sd30274, 17'sd31357, 17'sd32138, 17'sd32610, 17'sd32767, 17'sd32610,
      17'sd32138, 17'sd31357, 17'sd30274, 17'sd28899, 17'sd27246, 17'sd25330,
      17'sd23170, 17'sd20788, 17'sd18205, 17'sd15447, 17'sd12540, 17'sd9512,
      17'sd6393, 17'sd3212
   };

   // Reverses the low l bits of x; bits at and above l come out as zero.
   function automatic logic [ADDR_W-1:0] bit_rev(input logic [ADDR_W-1:0] x,
                                                 input logic [LOG2_W-1:0] l);
      logic [ADDR_W-1:0] y;
      y = '0;
      for (int i = 0; i < ADDR_W; i++) begin
         if (i < int'(l)) begin
            y[int'(l) - 1 - i] = x[i];
         end
      end
      return y;
   endfunction

endpackage

FILE: design/rfft_front.sv
// Front end: configuration registers, sample counting and command classification.
module rfft_front #(
   parameter int MAX_POINTS   = 64,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [rfft_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rfft_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_re,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_im,
   input  logic                                 req_last,
   output logic                                 push_valid,
   input  logic                                 push_ready,
   output rfft_pkg::cmd_type                    push_cmd,
   output logic signed [SAMPLE_WIDTH-1:0]       push_re,
   output logic signed [SAMPLE_WIDTH-1:0]       push_im
);
   import rfft_pkg::*;

   localparam int LG = $clog2(MAX_POINTS);

   logic [LOG2_W-1:0] log2_ff;
   logic              pad_en_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [LOG2_W-1:0] l_eff;
   logic [CNT_W-1:0]  n_pts;
   logic              store;
   logic [CNT_W-1:0]  count_next;
   logic              short_end;
   logic              accept;

   always_comb begin
      l_eff      = (log2_ff > LOG2_W'(LG)) ? LOG2_W'(LG) : log2_ff;
      n_pts      = CNT_W'(1) << l_eff;
      store      = count_ff < n_pts;
      count_next = count_ff + CNT_W'(store);
      short_end  = req_last && (count_next < n_pts);
      accept     = req_tvalid && push_ready;
      count_in   = accept ? (req_last ? '0 : count_next) : count_ff;
   end

   always_comb begin
      push_cmd.store    = store;
      push_cmd.last     = req_last;
      push_cmd.reject   = short_end && !pad_en_ff;
      push_cmd.pad      = short_end && pad_en_ff;
      push_cmd.log2n    = l_eff;
      push_cmd.addr     = bit_rev(count_ff[ADDR_W-1:0], l_eff);
      push_cmd.pad_from = count_next;
   end

   assign push_valid = req_tvalid;
   assign req_tready = push_ready;
   assign push_re    = req_re;
   assign push_im    = req_im;

   always_ff @(posedge clock) begin
      if (reset) begin
         log2_ff   <= LOG2_RESET;
         pad_en_ff <= PAD_RESET;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_LOG2_POINTS: log2_ff   <= csr_wdata;
               CSR_PAD_ENABLE:  pad_en_ff <= csr_wdata[0];
            endcase
         end
      end
   end

endmodule

FILE: design/rfft_queue.sv
// Short command queue that decouples the front end from the back end.
module rfft_queue #(
   parameter int WIDTH = 52
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   import rfft_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff;
   logic [PW-1:0]    rd_ptr_ff;
   logic [PW:0]      fill_ff;
   logic             do_push;
   logic             do_pop;

   assign push_ready = fill_ff != (PW + 1)'(QUEUE_DEPTH);
   assign pop_valid  = fill_ff != '0;
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
         fill_ff <= fill_ff + (PW + 1)'(do_push) - (PW + 1)'(do_pop);
      end
   end

endmodule

FILE: design/rfft_back.sv
// Back end: work memory, zero padding, pipelined butterfly unit and bin emission.
module rfft_back #(
   parameter int MAX_POINTS   = 64,
   parameter int SAMPLE_WIDTH = 16,
   parameter int BIN_WIDTH    = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              pop_valid,
   output logic                              pop_ready,
   input  rfft_pkg::cmd_type                 pop_cmd,
   input  logic signed [SAMPLE_WIDTH-1:0]    pop_re,
   input  logic signed [SAMPLE_WIDTH-1:0]    pop_im,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic signed [BIN_WIDTH-1:0]       bin_re,
   output logic signed [BIN_WIDTH-1:0]       bin_im,
   output logic [rfft_pkg::ADDR_W-1:0]       bin_index,
   output logic                              run_last,
   output logic                              short_frame
);
   import rfft_pkg::*;

   localparam int LG  = $clog2(MAX_POINTS);
   localparam int BW  = BIN_WIDTH;
   localparam int XW  = ((SAMPLE_WIDTH > BW) ? SAMPLE_WIDTH : BW) + 1;
   localparam int MW  = BW + TW_W;
   localparam int SW2 = MW + 2;

   localparam logic signed [XW-1:0]  X_HI = {{(XW - BW + 1){1'b0}}, {(BW - 1){1'b1}}};
   localparam logic signed [XW-1:0]  X_LO = {{(XW - BW + 1){1'b1}}, {(BW - 1){1'b0}}};
   localparam logic signed [SW2-1:0] S_HI = {{(SW2 - BW + 1){1'b0}}, {(BW - 1){1'b1}}};
   localparam logic signed [SW2-1:0] S_LO = {{(SW2 - BW + 1){1'b1}}, {(BW - 1){1'b0}}};
   localparam logic signed [SW2-1:0] ROUND_HALF = SW2'(16384);

   function automatic logic [BW-1:0] sat_sample(input logic [SAMPLE_WIDTH-1:0] x);
      logic signed [XW-1:0] xe;
      xe = {{(XW - SAMPLE_WIDTH){x[SAMPLE_WIDTH-1]}}, x};
      if (xe > X_HI) begin
         return X_HI[BW-1:0];
      end else if (xe < X_LO) begin
         return X_LO[BW-1:0];
      end
      return xe[BW-1:0];
   endfunction

   function automatic logic [BW-1:0] sat_bin(input logic signed [SW2-1:0] x);
      if (x > S_HI) begin
         return S_HI[BW-1:0];
      end else if (x < S_LO) begin
         return S_LO[BW-1:0];
      end
      return x[BW-1:0];
   endfunction

   // Work memory: {im, re} per entry, one write port, two registered read ports.
   logic [2*BW-1:0] mem [MAX_POINTS];
   logic [2*BW-1:0] rd_a_ff;
   logic [2*BW-1:0] rd_b_ff;

   back_state_type    state_ff;
   back_state_type    state_in;
   logic [LOG2_W-1:0] l_ff;
   logic [CNT_W-1:0]  pad_ff;
   logic [LOG2_W-1:0] stage_ff;
   logic [ADDR_W-1:0] bf_ff;
   logic              phase_ff;
   logic [CNT_W-1:0]  emit_idx_ff;
   logic              rd_pend_ff;
   logic [ADDR_W-1:0] bin_idx_ff;
   logic              v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic              rsp_valid_ff;

   logic [CNT_W-1:0]  n_pts;
   logic              bf_last;
   logic              stage_last;
   logic              busy;
   logic              out_free;
   logic              issue;
   logic              pad_wr;
   logic              store_wr;
   logic              load_bin;
   logic              load_err;
   logic              emit_rd;
   logic              rd_en_a;
   logic [LG-1:0]     rd_addr_a;

   // Butterfly addressing for the current stage and butterfly number.
   logic [ADDR_W-1:0] j_off;
   logic [ADDR_W-1:0] a_idx;
   logic [ADDR_W-1:0] b_idx;
   logic [4:0]        tw_idx;
   logic [ADDR_W-1:0] pad_addr;

   // Pipeline registers.
   logic signed [TW_W-1:0] tw_c_ff, tw_s_ff;
   logic [LG-1:0]          pa1_ff, pb1_ff, pa2_ff, pb2_ff, pa3_ff, pb3_ff, pa4_ff, pb4_ff;
   logic signed [MW-1:0]   m_rc_ff, m_is_ff, m_ic_ff, m_rs_ff;
   logic [2*BW-1:0]        a2_ff, a3_ff;
   logic signed [SW2-1:0]  pr_ff, pi_ff;
   logic [2*BW-1:0]        res_a_ff, res_b_ff;

   logic signed [BW-1:0]   br, bi;
   logic signed [SW2-1:0]  sum_r, sum_i;
   logic signed [SW2-1:0]  ar_e, ai_e;

   logic              wr_en;
   logic [LG-1:0]     wr_addr;
   logic [2*BW-1:0]   wr_data;

   always_comb begin
      n_pts      = CNT_W'(1) << l_ff;
      bf_last    = bf_ff == (ADDR_W'(n_pts >> 1) - ADDR_W'(1));
      stage_last = stage_ff == (l_ff - LOG2_W'(1));
      busy       = v1_ff || v2_ff || v3_ff || v4_ff || v5_ff;
      out_free   = !rsp_valid_ff || rsp_tready;
      j_off      = bf_ff & ((ADDR_W'(1) << stage_ff) - ADDR_W'(1));
      a_idx      = ((bf_ff >> stage_ff) << (stage_ff + LOG2_W'(1))) | j_off;
      b_idx      = a_idx | (ADDR_W'(1) << stage_ff);
      tw_idx     = 5'(j_off << (LOG2_W'(5) - stage_ff));
      pad_addr   = bit_rev(pad_ff[ADDR_W-1:0], l_ff);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (pop_valid && pop_cmd.last) begin
               if (pop_cmd.reject) begin
                  state_in = B_ERROR;
               end else if (pop_cmd.pad) begin
                  state_in = B_PAD;
               end else if (pop_cmd.log2n == '0) begin
                  state_in = B_EMIT;
               end else begin
                  state_in = B_FFT;
               end
            end
         end
         B_PAD: begin
            if (pad_ff == n_pts - CNT_W'(1)) begin
               state_in = B_FFT;
            end
         end
         B_FFT: begin
            if (!phase_ff && bf_last) begin
               state_in = B_DRAIN;
            end
         end
         B_DRAIN: begin
            if (!busy) begin
               state_in = stage_last ? B_EMIT : B_FFT;
            end
         end
         B_EMIT: begin
            if (emit_idx_ff == n_pts && !rd_pend_ff) begin
               state_in = B_IDLE;
            end
         end
         B_ERROR: begin
            if (out_free) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      pop_ready = state_ff == B_IDLE;
      issue     = (state_ff == B_FFT) && !phase_ff;
      pad_wr    = state_ff == B_PAD;
      store_wr  = pop_valid && pop_ready && pop_cmd.store;
      load_bin  = (state_ff == B_EMIT) && rd_pend_ff && out_free;
      emit_rd   = (state_ff == B_EMIT) && (emit_idx_ff < n_pts) && (!rd_pend_ff || load_bin);
      load_err  = (state_ff == B_ERROR) && out_free;
      rd_en_a   = issue || emit_rd;
      rd_addr_a = issue ? a_idx[LG-1:0] : emit_idx_ff[LG-1:0];
   end

   // Write port: butterfly results, zero padding, or a newly stored sample.
   always_comb begin
      wr_en   = 1'b1;
      wr_addr = pa4_ff;
      wr_data = res_a_ff;
      if (v4_ff) begin
         wr_addr = pa4_ff;
         wr_data = res_a_ff;
      end else if (v5_ff) begin
         wr_addr = pb4_ff;
         wr_data = res_b_ff;
      end else if (pad_wr) begin
         wr_addr = pad_addr[LG-1:0];
         wr_data = '0;
      end else if (store_wr) begin
         wr_addr = pop_cmd.addr[LG-1:0];
         wr_data = {sat_sample(pop_im), sat_sample(pop_re)};
      end else begin
         wr_en = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en_a) begin
         rd_a_ff <= mem[rd_addr_a];
      end
      if (issue) begin
         rd_b_ff <= mem[b_idx[LG-1:0]];
      end
   end

   // Butterfly datapath.
   assign br = rd_b_ff[BW-1:0];
   assign bi = rd_b_ff[2*BW-1:BW];

   always_comb begin
      sum_r = {{2{m_rc_ff[MW-1]}}, m_rc_ff} + {{2{m_is_ff[MW-1]}}, m_is_ff} + ROUND_HALF;
      sum_i = {{2{m_ic_ff[MW-1]}}, m_ic_ff} - {{2{m_rs_ff[MW-1]}}, m_rs_ff} + ROUND_HALF;
      ar_e  = {{(SW2 - BW){a3_ff[BW-1]}}, a3_ff[BW-1:0]};
      ai_e  = {{(SW2 - BW){a3_ff[2*BW-1]}}, a3_ff[2*BW-1:BW]};
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         tw_c_ff <= TW_COS[tw_idx];
         tw_s_ff <= TW_SIN[tw_idx];
         pa1_ff  <= a_idx[LG-1:0];
         pb1_ff  <= b_idx[LG-1:0];
      end
      if (v1_ff) begin
         m_rc_ff <= br * tw_c_ff;
         m_is_ff <= bi * tw_s_ff;
         m_ic_ff <= bi * tw_c_ff;
         m_rs_ff <= br * tw_s_ff;
         a2_ff   <= rd_a_ff;
         pa2_ff  <= pa1_ff;
         pb2_ff  <= pb1_ff;
      end
      if (v2_ff) begin
         pr_ff  <= sum_r >>> 15;
         pi_ff  <= sum_i >>> 15;
         a3_ff  <= a2_ff;
         pa3_ff <= pa2_ff;
         pb3_ff <= pb2_ff;
      end
      if (v3_ff) begin
         res_a_ff <= {sat_bin(ai_e + pi_ff), sat_bin(ar_e + pr_ff)};
         res_b_ff <= {sat_bin(ai_e - pi_ff), sat_bin(ar_e - pr_ff)};
         pa4_ff   <= pa3_ff;
         pb4_ff   <= pb3_ff;
      end
   end

   // Sequencer registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         l_ff         <= '0;
         pad_ff       <= '0;
         stage_ff     <= '0;
         bf_ff        <= '0;
         phase_ff     <= 1'b0;
         emit_idx_ff  <= '0;
         rd_pend_ff   <= 1'b0;
         bin_idx_ff   <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         v1_ff    <= issue;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         v4_ff    <= v3_ff;
         v5_ff    <= v4_ff;
         if (pop_valid && pop_ready && pop_cmd.last) begin
            l_ff        <= pop_cmd.log2n;
            pad_ff      <= pop_cmd.pad_from;
            stage_ff    <= '0;
            bf_ff       <= '0;
            phase_ff    <= 1'b0;
            emit_idx_ff <= '0;
         end
         if (pad_wr) begin
            pad_ff <= pad_ff + CNT_W'(1);
         end
         if (state_ff == B_FFT) begin
            phase_ff <= !phase_ff;
            if (issue) begin
               bf_ff <= bf_ff + ADDR_W'(1);
            end
         end
         if (state_ff == B_DRAIN && !busy && !stage_last) begin
            stage_ff <= stage_ff + LOG2_W'(1);
            bf_ff    <= '0;
            phase_ff <= 1'b0;
         end
         if (emit_rd) begin
            emit_idx_ff <= emit_idx_ff + CNT_W'(1);
            bin_idx_ff  <= emit_idx_ff[ADDR_W-1:0];
            rd_pend_ff  <= 1'b1;
         end else if (load_bin) begin
            rd_pend_ff  <= 1'b0;
         end
         if (load_bin || load_err) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (load_bin) begin
         bin_re      <= rd_a_ff[BW-1:0];
         bin_im      <= rd_a_ff[2*BW-1:BW];
         bin_index   <= bin_idx_ff;
         run_last    <= {1'b0, bin_idx_ff} == (n_pts - CNT_W'(1));
         short_frame <= 1'b0;
      end else if (load_err) begin
         bin_re      <= '0;
         bin_im      <= '0;
         bin_index   <= '0;
         run_last    <= 1'b1;
         short_frame <= 1'b1;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   // Butterfly issue is never back to back, so the two
   // write-back slots of one butterfly never collide with the next one.
   a_issue_spacing: assert property (@(posedge clock) disable iff (reset)
      issue |=> !issue)
      else $error("butterflies issued on consecutive cycles");

   // Bins are read only after the last butterfly has been written back.
   a_emit_after_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_EMIT) |-> !busy)
      else $error("bin emission overlaps butterfly pipeline");

   // A rejected frame gives a single closing result with zero values.
   a_short_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && short_frame) |-> (run_last && bin_index == '0 &&
                                         bin_re == '0 && bin_im == '0))
      else $error("short frame result malformed");

   // The command queue is not drained while a frame is being transformed.
   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_FFT || state_ff == B_DRAIN) |-> !(pop_ready || pad_wr))
      else $error("command taken during transform");

endmodule

FILE: design/radix2_fft_frame.sv
// Top level of the frame-based radix-2 decimation-in-time FFT.
//
//   Channel   Direction  Payload
//   req_*     in         tdata = {sample_im, sample_re}, tlast = frame_end
//   rsp_*     out        tdata = {bin_index, bin_im, bin_re}, tlast = run_last,
//                        tuser = short_frame
//   csr_*     in         write enable, register index, write data
//
// Samples are taken one word per cycle while the command queue has room; each
// of the first N is written to the work memory at its bit-reversed position. At
// frame end the back end pads a short frame if padding is on, then runs log2(N)
// stages of N/2 butterflies on one pipelined butterfly unit. The single write
// port of the work memory takes the two results of each butterfly in turn, and
// each stage ends with a drain of the butterfly pipeline. Reset is synchronous
// and active high and clears all control state; the work memory itself is not
// cleared. The result register holds one bin while rsp_tready is low, and the
// back end then waits with the next bin already read from the work memory. The
// queue lets up to four samples of the next frame enter while the current one
// is transformed.
module radix2_fft_frame #(
   parameter int  MAX_POINTS   = 64,
   parameter int  SAMPLE_WIDTH = 16,
   parameter int  BIN_WIDTH    = 24,
   localparam int REQ_W        = ((2 * SAMPLE_WIDTH + 7) / 8) * 8,
   localparam int RSP_W        = ((2 * BIN_WIDTH + rfft_pkg::ADDR_W + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [rfft_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rfft_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [REQ_W-1:0]                  req_tdata,   // sample_re, sample_im
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [RSP_W-1:0]                  rsp_tdata,   // bin_re, bin_im, bin_index
   output logic                              rsp_tlast,
   output logic                              rsp_tuser    // short_frame
);
   import rfft_pkg::*;

   localparam int QW = $bits(cmd_type) + 2 * SAMPLE_WIDTH;

   logic                            f_valid;
   logic                            f_ready;
   cmd_type                         f_cmd;
   logic signed [SAMPLE_WIDTH-1:0]  f_re;
   logic signed [SAMPLE_WIDTH-1:0]  f_im;
   logic                            q_valid;
   logic                            q_ready;
   logic [QW-1:0]                   q_data;
   cmd_type                         q_cmd;
   logic signed [BIN_WIDTH-1:0]     bin_re;
   logic signed [BIN_WIDTH-1:0]     bin_im;
   logic [ADDR_W-1:0]               bin_index;

   rfft_front #(
      .MAX_POINTS   (MAX_POINTS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_re     (req_tdata[SAMPLE_WIDTH-1:0]),
      .req_im     (req_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
      .req_last   (req_tlast),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_cmd   (f_cmd),
      .push_re    (f_re),
      .push_im    (f_im)
   );

   rfft_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  ({f_cmd, f_im, f_re}),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_data)
   );

   assign q_cmd = q_data[QW-1:2*SAMPLE_WIDTH];

   rfft_back #(
      .MAX_POINTS   (MAX_POINTS),
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .BIN_WIDTH    (BIN_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (q_valid),
      .pop_ready   (q_ready),
      .pop_cmd     (q_cmd),
      .pop_re      (q_data[SAMPLE_WIDTH-1:0]),
      .pop_im      (q_data[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .bin_re      (bin_re),
      .bin_im      (bin_im),
      .bin_index   (bin_index),
      .run_last    (rsp_tlast),
      .short_frame (rsp_tuser)
   );

   assign rsp_tdata = RSP_W'({bin_index, bin_im, bin_re});

endmodule
